// File: rtl/core/rglow_pkg.sv
// Package for the radial glow blend block.
// Holds channel and gain widths and configuration register indexes; no dependencies.
package rglow_pkg;
    localparam int CH_W      = 8;
    localparam int GAIN_W    = 10;
    localparam int REG_IDX_W = 2;
    localparam logic [REG_IDX_W-1:0] REG_CENTER_X = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_CENTER_Y = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_RADIUS   = 2'd2;
    localparam logic [REG_IDX_W-1:0] REG_GAIN     = 2'd3;
    localparam logic [GAIN_W-1:0]    GAIN_RESET   = 10'd256;
    localparam logic [CH_W-1:0]      CH_MAX       = 8'd255;

    typedef logic [3*CH_W-1:0] t_rgb;
endpackage

// File: rtl/core/radial_glow_blend.sv
// Radial glow blend: one pixel request per clock, fully pipelined, no stall path.
// Each pixel passes stage A (absolute differences), stage B (squared distance), the square
// root pipeline (one root bit per stage), stage C (inside test), stage D (fade product),
// the quotient pipeline (one quotient bit per stage) and the saturating add output stage.
// Throughput: one pixel every cycle. Synchronous active-low reset clears valid bits and
// loads register defaults. Depends on rglow_pkg.
module radial_glow_blend
    import rglow_pkg::*;
#(
    parameter int COORD_BITS     = 12,
    parameter int DIST_FRAC_BITS = 4
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic                  i_cfg_we,
    input  logic [REG_IDX_W-1:0]  i_cfg_idx,
    input  logic [((COORD_BITS > GAIN_W) ? COORD_BITS : GAIN_W)-1:0] i_cfg_data,
    input  logic [COORD_BITS-1:0] i_pixel_x,
    input  logic [COORD_BITS-1:0] i_pixel_y,
    input  logic [CH_W-1:0]       i_red_in,
    input  logic [CH_W-1:0]       i_green_in,
    input  logic [CH_W-1:0]       i_blue_in,
    output logic                  o_valid,
    output logic [CH_W-1:0]       o_red_out,
    output logic [CH_W-1:0]       o_green_out,
    output logic [CH_W-1:0]       o_blue_out,
    output logic                  o_in_glow
);
    localparam int C     = COORD_BITS;
    localparam int F     = DIST_FRAC_BITS;
    localparam int VW    = 2 * C + 1 + 2 * F;
    localparam int RW    = (VW + 1) / 2;
    localparam int SW    = 2 * RW;
    localparam int RADW  = C + F;
    localparam int NW    = RADW + GAIN_W;
    localparam int QW    = GAIN_W;

    // configuration
    logic [C-1:0]      r_cx, r_cy, r_radius;
    logic [GAIN_W-1:0] r_gain;
    logic [RADW-1:0]   rad;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cx     <= '0;
            r_cy     <= '0;
            r_radius <= '0;
            r_gain   <= GAIN_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_CENTER_X: r_cx     <= i_cfg_data[C-1:0];
                REG_CENTER_Y: r_cy     <= i_cfg_data[C-1:0];
                REG_RADIUS:   r_radius <= i_cfg_data[C-1:0];
                REG_GAIN:     r_gain   <= i_cfg_data[GAIN_W-1:0];
                default: ;
            endcase
        end
    end

    assign rad  = RADW'(r_radius) << F;
    assign busy = 1'b0;

    // stage A: absolute differences
    logic         r_a_vld;
    logic [C-1:0] r_a_dx, r_a_dy;
    t_rgb         r_a_rgb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else begin
            r_a_vld <= start;
        end
        r_a_dx  <= (i_pixel_x >= r_cx) ? i_pixel_x - r_cx : r_cx - i_pixel_x;
        r_a_dy  <= (i_pixel_y >= r_cy) ? i_pixel_y - r_cy : r_cy - i_pixel_y;
        r_a_rgb <= {i_red_in, i_green_in, i_blue_in};
    end

    // stage B: squared distance, scaled for fraction bits
    logic          r_b_vld;
    logic [SW-1:0] r_b_v;
    t_rgb          r_b_rgb;
    logic [VW-1:0] d2;

    assign d2 = VW'({C'(0), r_a_dx} * {C'(0), r_a_dx})
                + VW'({C'(0), r_a_dy} * {C'(0), r_a_dy});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld <= 1'b0;
        end else begin
            r_b_vld <= r_a_vld;
        end
        r_b_v   <= SW'(d2) << (2 * F);
        r_b_rgb <= r_a_rgb;
    end

    // square root pipeline: one root bit per stage
    logic          r_sq_vld  [RW];
    logic [RW+1:0] r_sq_rem  [RW];
    logic [RW-1:0] r_sq_root [RW];
    logic [SW-1:0] r_sq_v    [RW];
    t_rgb          r_sq_rgb  [RW];

    logic [RW+1:0] n_sq_rem  [RW];
    logic [RW-1:0] n_sq_root [RW];

    always_comb begin
        for (int s = 0; s < RW; s++) begin
            logic [RW+1:0] rem_in;
            logic [RW+1:0] trial;
            logic [RW-1:0] root_in;
            logic [SW-1:0] v_in;
            rem_in  = '0;
            trial   = '0;
            if (s == 0) begin
                root_in = '0;
                v_in    = r_b_v;
                rem_in  = {RW'(0), v_in[SW-1 -: 2]};
            end else begin
                root_in = r_sq_root[s-1];
                v_in    = r_sq_v[s-1];
                rem_in  = {r_sq_rem[s-1][RW-1:0], v_in[SW-1 -: 2]};
            end
            trial = {root_in, 2'b01};
            if (rem_in >= trial) begin
                n_sq_rem[s]  = rem_in - trial;
                n_sq_root[s] = {root_in[RW-2:0], 1'b1};
            end else begin
                n_sq_rem[s]  = rem_in;
                n_sq_root[s] = {root_in[RW-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < RW; s++) r_sq_vld[s] <= 1'b0;
        end else begin
            r_sq_vld[0] <= r_b_vld;
            for (int s = 1; s < RW; s++) r_sq_vld[s] <= r_sq_vld[s-1];
        end
        r_sq_v[0]   <= r_b_v << 2;
        r_sq_rgb[0] <= r_b_rgb;
        for (int s = 1; s < RW; s++) begin
            r_sq_v[s]   <= r_sq_v[s-1] << 2;
            r_sq_rgb[s] <= r_sq_rgb[s-1];
        end
        for (int s = 0; s < RW; s++) begin
            r_sq_rem[s]  <= n_sq_rem[s];
            r_sq_root[s] <= n_sq_root[s];
        end
    end

    // stage C: inside test and distance to the rim
    logic            r_c_vld, r_c_in;
    logic [RADW-1:0] r_c_diff;
    t_rgb            r_c_rgb;
    logic [RW-1:0]   root_dist;
    logic            in_rad;

    assign root_dist = r_sq_root[RW-1];
    assign in_rad    = (rad != '0) && (root_dist < RW'(rad));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_vld <= 1'b0;
        end else begin
            r_c_vld <= r_sq_vld[RW-1];
        end
        r_c_in   <= in_rad;
        r_c_diff <= in_rad ? RADW'(RW'(rad) - root_dist) : '0;
        r_c_rgb  <= r_sq_rgb[RW-1];
    end

    // stage D: fade numerator, diff * gain * 255 / 256
    logic            r_d_vld, r_d_in;
    logic [NW-1:0]   r_d_num;
    t_rgb            r_d_rgb;
    logic [NW-1:0]   prod;
    logic [NW+7:0]   prod255;

    assign prod    = NW'(r_c_diff) * NW'(r_gain);
    assign prod255 = ({8'd0, prod} << 8) - {8'd0, prod};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_vld <= 1'b0;
        end else begin
            r_d_vld <= r_c_vld;
        end
        r_d_in  <= r_c_in;
        r_d_num <= prod255[NW+7:8];
        r_d_rgb <= r_c_rgb;
    end

    // quotient pipeline: one quotient bit per stage, MSB first
    logic          r_dv_vld [QW];
    logic          r_dv_in  [QW];
    logic [NW-1:0] r_dv_rem [QW];
    logic [QW-1:0] r_dv_q   [QW];
    t_rgb          r_dv_rgb [QW];

    logic [NW-1:0] n_dv_rem [QW];
    logic [QW-1:0] n_dv_q   [QW];

    always_comb begin
        for (int k = 0; k < QW; k++) begin
            logic [NW-1:0] rem_in;
            logic [QW-1:0] q_in;
            logic [NW-1:0] dsh;
            rem_in = (k == 0) ? r_d_num : r_dv_rem[(k == 0) ? 0 : k-1];
            q_in   = (k == 0) ? '0 : r_dv_q[(k == 0) ? 0 : k-1];
            dsh    = NW'(rad) << (QW - 1 - k);
            if (rem_in >= dsh) begin
                n_dv_rem[k] = rem_in - dsh;
                n_dv_q[k]   = {q_in[QW-2:0], 1'b1};
            end else begin
                n_dv_rem[k] = rem_in;
                n_dv_q[k]   = {q_in[QW-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < QW; k++) r_dv_vld[k] <= 1'b0;
        end else begin
            r_dv_vld[0] <= r_d_vld;
            for (int k = 1; k < QW; k++) r_dv_vld[k] <= r_dv_vld[k-1];
        end
        r_dv_in[0]  <= r_d_in;
        r_dv_rgb[0] <= r_d_rgb;
        for (int k = 1; k < QW; k++) begin
            r_dv_in[k]  <= r_dv_in[k-1];
            r_dv_rgb[k] <= r_dv_rgb[k-1];
        end
        for (int k = 0; k < QW; k++) begin
            r_dv_rem[k] <= n_dv_rem[k];
            r_dv_q[k]   <= n_dv_q[k];
        end
    end

    // output stage: saturating add on each channel
    logic          r_o_vld, r_o_in;
    t_rgb          r_o_rgb;
    logic [QW-1:0] add;
    t_rgb          src_rgb;
    t_rgb          sum_rgb;

    assign src_rgb = r_dv_rgb[QW-1];
    // drop the quotient outside the radius: a zero radius makes every trial pass
    assign add     = r_dv_in[QW-1] ? r_dv_q[QW-1] : '0;

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            logic [QW:0] s;
            s = {1'b0, add} + (QW+1)'(src_rgb[c*CH_W +: CH_W]);
            sum_rgb[c*CH_W +: CH_W] = (s > (QW+1)'(CH_MAX)) ? CH_MAX : s[CH_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else begin
            r_o_vld <= r_dv_vld[QW-1];
        end
        r_o_in  <= r_dv_in[QW-1];
        r_o_rgb <= sum_rgb;
    end

    assign o_valid     = r_o_vld;
    assign o_in_glow   = r_o_in;
    assign o_red_out   = r_o_rgb[3*CH_W-1 -: CH_W];
    assign o_green_out = r_o_rgb[2*CH_W-1 -: CH_W];
    assign o_blue_out  = r_o_rgb[CH_W-1:0];
endmodule
